// ----- rtl/csh_pkg.sv -----
// Shared types, constants and codes for the contrast stretch histogram block.
`default_nettype none
package csh_pkg;
   localparam int BinsDefault      = 256;
   localparam int CountBitsDefault = 23;
   localparam int PctMax           = 25600;
   localparam int PctBits          = 15;
   localparam int AddrBits         = 3;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   localparam logic [AddrBits-1:0] RegLowAddr  = 3'd0;
   localparam logic [AddrBits-1:0] RegHighAddr = 3'd4;

   // Classified command passed from the front part to the back part.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic [7:0] index;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIVIDE,
      ST_DONE
   } back_state_type;
endpackage
`default_nettype wire

// ----- rtl/csh_if.sv -----
// Valid/ready channel interfaces for the request and response words.
`default_nettype none
interface csh_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] pixel;
   logic [7:0] bin_index;
   modport source (output valid, kind, pixel, bin_index, input ready);
   modport sink (input valid, kind, pixel, bin_index, output ready);
endinterface

interface csh_rsp_if #(parameter int CountBits = 23);
   logic                 valid;
   logic                 ready;
   logic [7:0]           stretched_pixel;
   logic [CountBits-1:0] bin_count;
   logic [14:0]          bin_percent_q8;
   logic [7:0]           peak_bin;
   logic [CountBits-1:0] peak_count;
   logic [CountBits-1:0] total_pixels;
   modport source (output valid, stretched_pixel, bin_count, bin_percent_q8, peak_bin,
      peak_count, total_pixels, input ready);
   modport sink (input valid, stretched_pixel, bin_count, bin_percent_q8, peak_bin,
      peak_count, total_pixels, output ready);
endinterface
`default_nettype wire

// ----- rtl/csh_front.sv -----
// Front part: stretches pixels through a serial divider and holds each command in an output register.
`default_nettype none
module csh_front
   import csh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] low,
   input  wire logic [7:0] high,
   csh_req_if.sink         req,
   output cmd_type         cmd_data,
   output logic            cmd_valid,
   input  wire logic       cmd_ready
);
   // Long division of 255*(p-low) by (high-low), one quotient bit a cycle.
   logic        busy_ff, busy_in;
   logic [3:0]  step_ff, step_in;
   logic [15:0] rem_ff, rem_in;
   logic [7:0]  den_ff, den_in;
   logic [7:0]  quo_ff, quo_in;
   cmd_type     hold_ff, hold_in;
   logic        out_valid_ff, out_valid_in;
   cmd_type     out_ff, out_in;
   logic [16:0] trial;
   logic [7:0]  diff;
   logic        accept;

   assign req.ready = !busy_ff && !out_valid_ff;
   assign accept    = req.valid && req.ready;
   assign diff      = req.pixel - low;
   assign trial     = {1'b0, rem_ff} - ({9'd0, den_ff} << step_ff[2:0]);

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      hold_in      = hold_ff;
      out_valid_in = out_valid_ff && !cmd_ready;
      out_in       = out_ff;
      if (accept) begin
         hold_in.kind  = kind_type'(req.kind);
         hold_in.index = req.bin_index;
         hold_in.value = 8'd0;
         if (kind_type'(req.kind) == KIND_PIXEL && high > low && req.pixel > low &&
             req.pixel < high) begin
            busy_in = 1'b1;
            step_in = 4'd7;
            rem_in  = ({8'd0, diff} << 8) - {8'd0, diff};
            den_in  = high - low;
            quo_in  = 8'd0;
         end else begin
            if (kind_type'(req.kind) == KIND_PIXEL && high > low && req.pixel >= high) begin
               hold_in.value = 8'd255;
            end
            out_valid_in = 1'b1;
            out_in       = hold_in;
         end
      end else if (busy_ff) begin
         quo_in = {quo_ff[6:0], !trial[16]};
         if (!trial[16]) begin
            rem_in = trial[15:0];
         end
         if (step_ff == 4'd0) begin
            busy_in       = 1'b0;
            out_valid_in  = 1'b1;
            out_in        = hold_ff;
            out_in.value  = quo_in;
         end else begin
            step_in = step_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      hold_ff <= hold_in;
      out_ff  <= out_in;
   end

   assign cmd_valid = out_valid_ff;
   assign cmd_data  = out_ff;
endmodule
`default_nettype wire

// ----- rtl/csh_queue.sv -----
// Two-entry queue between the front and back parts.
`default_nettype none
module csh_queue
   import csh_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  cmd_type   in_data,
   input  wire logic in_valid,
   output logic      in_ready,
   output cmd_type   out_data,
   output logic      out_valid,
   input  wire logic out_ready
);
   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign wp_in     = wp_ff ^ push;
   assign rp_in     = rp_ff ^ pop;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/csh_back.sv -----
// Back part: histogram memory, peak and total tracking, percentage divider.
`default_nettype none
module csh_back
   import csh_pkg::*;
#(
   parameter int Bins      = BinsDefault,
   parameter int CountBits = CountBitsDefault
)(
   input  wire logic clock,
   input  wire logic reset,
   input  cmd_type   cmd_data,
   input  wire logic cmd_valid,
   output logic      cmd_ready,
   csh_rsp_if.source rsp
);
   localparam int IdxBits = $clog2(Bins);
   localparam int NumBits = CountBits + PctBits;
   localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

   back_state_type state_ff, state_in;
   logic [CountBits-1:0] mem [Bins];
   logic [Bins-1:0]      valid_ff;
   logic [CountBits-1:0] rd_ff;
   cmd_type              cmd_ff;
   logic [CountBits-1:0] total_ff, peak_val_ff;
   logic [7:0]           peak_idx_ff;
   logic [NumBits-1:0]   num_ff;
   logic [CountBits:0]   rem_ff;
   logic [5:0]           cnt_ff;
   logic [CountBits-1:0] cnum;
   logic [CountBits:0]   shifted, sub;
   logic                 take, wr_en;
   logic [CountBits-1:0] inc;
   logic [IdxBits-1:0]   addr;

   logic                 ovalid_ff;
   logic [7:0]           o_sp_ff;
   logic [CountBits-1:0] o_bc_ff;
   logic [PctBits-1:0]   o_pct_ff;

   assign take      = cmd_valid && cmd_ready;
   assign cmd_ready = state_ff == ST_IDLE && !ovalid_ff;
   assign addr      = (cmd_ff.kind == KIND_PIXEL) ? cmd_ff.value[IdxBits-1:0]
                                                  : cmd_ff.index[IdxBits-1:0];
   assign cnum      = valid_ff[addr] ? rd_ff : '0;
   assign inc       = (cnum == CountMax) ? cnum : cnum + 1'b1;
   assign wr_en     = state_ff == ST_READ && cmd_ff.kind == KIND_PIXEL;
   assign shifted   = {rem_ff[CountBits-1:0], num_ff[NumBits-1]};
   assign sub       = shifted - {1'b0, total_ff};

   always_comb begin
      unique case (state_ff)
         ST_IDLE:   state_in = take ? ST_READ : ST_IDLE;
         ST_READ:   state_in = (cmd_ff.kind == KIND_READ && total_ff != '0) ? ST_DIVIDE
                                                                             : ST_DONE;
         ST_DIVIDE: state_in = (cnt_ff == 6'd0) ? ST_DONE : ST_DIVIDE;
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_data;
      end
      rd_ff <= mem[cmd_data.kind == KIND_PIXEL ? cmd_data.value[IdxBits-1:0]
                                               : cmd_data.index[IdxBits-1:0]];
      if (wr_en) begin
         mem[addr] <= inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         total_ff    <= '0;
         peak_val_ff <= '0;
         peak_idx_ff <= '0;
         ovalid_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         if (ovalid_ff && rsp.ready) begin
            ovalid_ff <= 1'b0;
         end
         if (state_ff == ST_READ) begin
            o_sp_ff  <= '0;
            o_bc_ff  <= '0;
            o_pct_ff <= '0;
            unique case (cmd_ff.kind)
               KIND_PIXEL: begin
                  o_sp_ff         <= cmd_ff.value;
                  valid_ff[addr]  <= 1'b1;
                  if (total_ff != CountMax) begin
                     total_ff <= total_ff + 1'b1;
                  end
                  if (inc > peak_val_ff || (inc == peak_val_ff && cmd_ff.value < peak_idx_ff))
                  begin
                     peak_val_ff <= inc;
                     peak_idx_ff <= cmd_ff.value;
                  end
               end
               KIND_READ: begin
                  o_bc_ff <= cnum;
                  // Numerator is count*25600 = (count*100) << 8.
                  num_ff  <= NumBits'({(CountBits+7)'(cnum) * 7'd100, 8'd0});
                  rem_ff  <= '0;
                  cnt_ff  <= 6'(NumBits - 1);
               end
               KIND_CLEAR: begin
                  valid_ff    <= '0;
                  total_ff    <= '0;
                  peak_val_ff <= '0;
                  peak_idx_ff <= '0;
               end
               default: ;
            endcase
         end else if (state_ff == ST_DIVIDE) begin
            num_ff <= {num_ff[NumBits-2:0], !sub[CountBits]};
            rem_ff <= sub[CountBits] ? shifted : sub;
            cnt_ff <= cnt_ff - 6'd1;
         end else if (state_ff == ST_DONE) begin
            ovalid_ff <= 1'b1;
            if (cmd_ff.kind == KIND_READ && total_ff != '0) begin
               // Quotient never exceeds 25600 because a bin never exceeds the total.
               o_pct_ff <= (num_ff > NumBits'(PctMax)) ? PctBits'(PctMax)
                                                       : num_ff[PctBits-1:0];
            end
         end
      end
   end

   assign rsp.valid           = ovalid_ff;
   assign rsp.stretched_pixel = o_sp_ff;
   assign rsp.bin_count       = o_bc_ff;
   assign rsp.bin_percent_q8  = o_pct_ff;
   assign rsp.peak_bin        = peak_idx_ff;
   assign rsp.peak_count      = peak_val_ff;
   assign rsp.total_pixels    = total_ff;
endmodule
`default_nettype wire

// ----- rtl/contrast_stretch_histogram.sv -----
// Top level of the contrast stretch histogram block.
// Pixels are stretched in the front part by a bit-serial divider (clamped pixels and
// other words bypass it), then counted by the back part, which steps each word
// through its read and done states and a bin read with a nonzero total also through
// its serial percentage divider; a two-word queue lets the parts stall
// independently. Registers stretch_low at byte 0 and stretch_high at byte 4 must be
// written only while idle; the block itself does not enforce this.
`default_nettype none
module contrast_stretch_histogram
   import csh_pkg::*;
#(
   parameter int Bins      = BinsDefault,
   parameter int CountBits = CountBitsDefault
)(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [AddrBits-1:0] paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready,
   csh_req_if.sink                  req,
   csh_rsp_if.source                rsp
);
   logic [7:0] low_ff, high_ff;
   cmd_type    f_data, q_data;
   logic       f_valid, f_ready, q_valid, q_ready;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= 8'd0;
         high_ff <= 8'd255;
      end else if (psel && penable && pwrite) begin
         if (paddr == RegLowAddr) begin
            low_ff <= pwdata[7:0];
         end else if (paddr == RegHighAddr) begin
            high_ff <= pwdata[7:0];
         end
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr == RegLowAddr) begin
         prdata = {24'd0, low_ff};
      end else if (paddr == RegHighAddr) begin
         prdata = {24'd0, high_ff};
      end
   end

   csh_front u_front (
      .clock, .reset, .low(low_ff), .high(high_ff), .req,
      .cmd_data(f_data), .cmd_valid(f_valid), .cmd_ready(f_ready)
   );

   csh_queue u_queue (
      .clock, .reset, .in_data(f_data), .in_valid(f_valid), .in_ready(f_ready),
      .out_data(q_data), .out_valid(q_valid), .out_ready(q_ready)
   );

   csh_back #(.Bins(Bins), .CountBits(CountBits)) u_back (
      .clock, .reset, .cmd_data(q_data), .cmd_valid(q_valid), .cmd_ready(q_ready), .rsp
   );
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the contrast stretch histogram block: random and directed words, self-checking.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import csh_pkg::*;

   localparam int CountBits = 23;
   localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
   localparam int WatchLimit = 20000;

   typedef struct packed {
      logic [7:0]           stretched_pixel;
      logic [CountBits-1:0] bin_count;
      logic [14:0]          bin_percent_q8;
      logic [7:0]           peak_bin;
      logic [CountBits-1:0] peak_count;
      logic [CountBits-1:0] total_pixels;
   } hist_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [AddrBits-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   csh_req_if req ();
   csh_rsp_if #(.CountBits(CountBits)) rsp ();

   contrast_stretch_histogram #(.CountBits(CountBits)) uut (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .req(req.sink), .rsp(rsp.source)
   );

   always #5 clock = ~clock;

   // Predictor state.
   logic [7:0] low_q = 8'd0;
   logic [7:0] high_q = 8'd255;
   logic [CountBits-1:0] counts_q [256];
   logic [CountBits-1:0] total_q;
   logic [7:0] peak_bin_q;
   logic [CountBits-1:0] peak_count_q;

   hist_result_type expected_results[$];
   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;

   function automatic logic [7:0] stretch_value(logic [7:0] p);
      int v;
      begin
         if (high_q <= low_q || p <= low_q) return 8'd0;
         if (p >= high_q) return 8'd255;
         v = (255 * (p - low_q)) / (high_q - low_q);
         return (v > 255) ? 8'd255 : v[7:0];
      end
   endfunction

   function automatic void clear_histogram();
      foreach (counts_q[i]) counts_q[i] = '0;
      total_q = '0;
      peak_bin_q = '0;
      peak_count_q = '0;
   endfunction

   function automatic hist_result_type predict_histogram(kind_type k, logic [7:0] p,
                                                         logic [7:0] b);
      hist_result_type r;
      logic [CountBits-1:0] c;
      longint pct;
      begin
         r = '0;
         case (k)
            KIND_PIXEL: begin
               r.stretched_pixel = stretch_value(p);
               c = counts_q[r.stretched_pixel];
               if (c != CountMax) c = c + 1'b1;
               counts_q[r.stretched_pixel] = c;
               if (total_q != CountMax) total_q = total_q + 1'b1;
               if (c > peak_count_q || (c == peak_count_q && r.stretched_pixel < peak_bin_q)) begin
                  peak_count_q = c;
                  peak_bin_q = r.stretched_pixel;
               end
            end
            KIND_READ: begin
               r.bin_count = counts_q[b];
               if (total_q != 0) begin
                  pct = (longint'(r.bin_count) * PctMax) / total_q;
                  if (pct > PctMax) pct = PctMax;
                  r.bin_percent_q8 = pct[14:0];
               end
            end
            KIND_CLEAR: clear_histogram();
            default: ;
         endcase
         r.peak_bin = peak_bin_q;
         r.peak_count = peak_count_q;
         r.total_pixels = total_q;
         return r;
      end
   endfunction

   task automatic send_word(kind_type k, logic [7:0] p, logic [7:0] b);
      hist_result_type e;
      int gap;
      begin
         // Bursts of random length with random gaps between them.
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
               req.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(1, 20);
         end
         burst_left--;
         req.valid <= 1'b1;
         req.kind <= k;
         req.pixel <= p;
         req.bin_index <= b;
         @(posedge clock);
         while (!req.ready) @(posedge clock);
         e = predict_histogram(k, p, b);
         expected_results.push_back(e);
         @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      begin
         req.valid <= 1'b0;
         while (expected_results.size() != 0) @(negedge clock);
         repeat (60) @(negedge clock);
      end
   endtask

   task automatic write_register(logic [AddrBits-1:0] addr, logic [7:0] value);
      begin
         psel <= 1'b1;
         pwrite <= 1'b1;
         paddr <= addr;
         pwdata <= {24'd0, value};
         @(negedge clock);
         penable <= 1'b1;
         @(negedge clock);
         psel <= 1'b0;
         penable <= 1'b0;
         pwrite <= 1'b0;
         if (addr == RegLowAddr) low_q = value;
         else high_q = value;
      end
   endtask

   task automatic set_range(logic [7:0] lo, logic [7:0] hi);
      begin
         wait_drained();
         write_register(RegLowAddr, lo);
         write_register(RegHighAddr, hi);
      end
   endtask

   task automatic test_directed();
      begin
         send_word(KIND_READ, 8'd0, 8'd0);        // no pixels yet
         send_word(KIND_PIXEL, 8'd0, 8'd0);
         send_word(KIND_PIXEL, 8'd255, 8'hFF);
         send_word(KIND_PIXEL, 8'd128, 8'd0);
         send_word(KIND_PIXEL, 8'd255, 8'd0);     // bin 255 leads; next word ties on bin 0
         send_word(KIND_PIXEL, 8'd0, 8'd0);
         send_word(KIND_READ, 8'hAA, 8'd0);
         send_word(KIND_READ, 8'h55, 8'd255);
         send_word(KIND_READ, 8'd0, 8'd17);       // never-written bin reads zero
         send_word(KIND_NONE, 8'hFF, 8'hFF);
         send_word(KIND_CLEAR, 8'h0F, 8'hF0);
         send_word(KIND_READ, 8'd0, 8'd0);
         set_range(8'd50, 8'd100);
         send_word(KIND_PIXEL, 8'd10, 8'd0);      // below low
         send_word(KIND_PIXEL, 8'd50, 8'd0);
         send_word(KIND_PIXEL, 8'd75, 8'd0);
         send_word(KIND_PIXEL, 8'd99, 8'd0);
         send_word(KIND_PIXEL, 8'd200, 8'd0);     // above high
         send_word(KIND_READ, 8'd0, 8'd255);
         set_range(8'd100, 8'd100);               // empty range
         send_word(KIND_PIXEL, 8'd150, 8'd0);
         set_range(8'd200, 8'd10);
         send_word(KIND_PIXEL, 8'd100, 8'd0);
         send_word(KIND_READ, 8'd0, 8'd0);
      end
   endtask

   task automatic test_random(int n);
      int r;
      begin
         for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 75) send_word(KIND_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255));
            else if (r < 93) send_word(KIND_READ, $urandom_range(0, 255),
                                       ($urandom_range(0, 1) ? peak_bin_q : $urandom_range(0, 255)));
            else if (r < 97) send_word(KIND_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
            else send_word(KIND_NONE, $urandom_range(0, 255), $urandom_range(0, 255));
         end
      end
   endtask

   task automatic test_ranges();
      begin
         set_range(8'd0, 8'd255);
         test_random(300);
         set_range($urandom_range(0, 120), $urandom_range(130, 255));
         test_random(300);
         set_range(8'd0, 8'd1);
         test_random(100);
         set_range(8'd254, 8'd255);
         test_random(100);
         set_range(8'd255, 8'd0);
         test_random(50);
         set_range(8'd0, 8'd255);
         test_random(80);
      end
   endtask

   // Result checker; the receiver stalls on a changing pattern.
   always @(posedge clock) begin
      hist_result_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result word");
            errors++;
         end else begin
            e = expected_results.pop_front();
            if (rsp.stretched_pixel !== e.stretched_pixel) begin
               $error("stretched_pixel exp %0d got %0d", e.stretched_pixel, rsp.stretched_pixel);
               errors++;
            end
            if (rsp.bin_count !== e.bin_count) begin
               $error("bin_count exp %0d got %0d", e.bin_count, rsp.bin_count);
               errors++;
            end
            if (rsp.bin_percent_q8 !== e.bin_percent_q8) begin
               $error("bin_percent_q8 exp %0d got %0d", e.bin_percent_q8, rsp.bin_percent_q8);
               errors++;
            end
            if (rsp.peak_bin !== e.peak_bin) begin
               $error("peak_bin exp %0d got %0d", e.peak_bin, rsp.peak_bin);
               errors++;
            end
            if (rsp.peak_count !== e.peak_count) begin
               $error("peak_count exp %0d got %0d", e.peak_count, rsp.peak_count);
               errors++;
            end
            if (rsp.total_pixels !== e.total_pixels) begin
               $error("total_pixels exp %0d got %0d", e.total_pixels, rsp.total_pixels);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= ($urandom_range(0, 3) != 0);
         2: rsp.ready <= ($urandom_range(0, 1) != 0);
         default: rsp.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Watchdog on cycles with no accepted word.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchLimit) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.kind = KIND_PIXEL;
      req.pixel = '0;
      req.bin_index = '0;
      rsp.ready = 1'b1;
      clear_histogram();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_ranges();
      wait_drained();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
